// ===== rtl/hcbd_pkg.sv =====
// ---------------------------------------------------------------------------
// hcbd_pkg: shared types and constants for the chunked body decoder
// Parse phases, status codes, character codes and the hex digit decoder.
// ---------------------------------------------------------------------------
package hcbd_pkg;

   localparam int SIZE_BITS_DEFAULT = 32;

   localparam logic [7:0] CHAR_CR   = 8'h0D;
   localparam logic [7:0] CHAR_LF   = 8'h0A;
   localparam logic [7:0] CHAR_SEMI = 8'h3B;

   typedef enum logic [2:0] {
      PH_SIZE    = 3'd0,
      PH_SIZE_CR = 3'd1,
      PH_EXT     = 3'd2,
      PH_EXT_CR  = 3'd3,
      PH_DATA    = 3'd4,
      PH_TRAIL1  = 3'd5,
      PH_TRAIL2  = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      ST_RUN   = 2'd0,
      ST_DONE  = 2'd1,
      ST_BAD   = 2'd2,
      ST_SHORT = 2'd3
   } status_type;

   // {is_hex, digit value}
   function automatic logic [4:0] hex_decode(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, 4'(b - 8'h30)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r = {1'b1, 4'(b - 8'h57)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r = {1'b1, 4'(b - 8'h37)};
      end
      return r;
   endfunction

endpackage

// ===== rtl/hcbd_if.sv =====
// ---------------------------------------------------------------------------
// hcbd request and response channels
// Valid/ready channels carrying encoded bytes in and decoded results out.
// ---------------------------------------------------------------------------
interface hcbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface hcbd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_valid;
   logic [1:0] status;
   logic       end_of_message;

   modport source (output valid, output out_byte, output out_valid, output status,
                   output end_of_message, input ready);
   modport sink   (input valid, input out_byte, input out_valid, input status,
                   input end_of_message, output ready);
endinterface

// ===== rtl/http_chunked_body_decoder.sv =====
// ---------------------------------------------------------------------------
// http_chunked_body_decoder: HTTP/1.1 chunked transfer body decoder
// Parses size lines, passes chunk payload through and reports message status.
// ---------------------------------------------------------------------------
// Usage:
//   req_chan carries one encoded body byte per request, with in_last set on
//   the final byte of the buffer. rsp_chan returns exactly one result per
//   request: the payload byte (out_valid), a status code (running, done,
//   invalid, incomplete) and end_of_message, a copy of in_last.
//   A request passes through the input register, then the parse logic into
//   the result register. Throughput is one request per clock while the
//   receiver takes results; the parse step and the state registers it
//   updates set that rate.
//   When the receiver stalls, the result register holds and the input
//   register fills; req_chan.ready drops only once both are occupied, and
//   rises again the cycle the result is taken.
//   Reset (synchronous, active high) empties both registers and returns the
//   parser to the start of a size line. After every request with in_last the
//   parser also returns to that state, so the next byte starts a new message.
//   After done or invalid, bytes are dropped up to in_last.
// ---------------------------------------------------------------------------
module http_chunked_body_decoder #(
   parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   hcbd_req_if.sink    req_chan,
   hcbd_rsp_if.source  rsp_chan
);

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // result register
   logic       rsp_valid_ff;
   logic [7:0] rsp_byte_ff,  rsp_byte_in;
   logic       rsp_dv_ff,    rsp_dv_in;
   logic [1:0] rsp_status_ff;
   logic       rsp_eom_ff;
   hcbd_pkg::status_type status_in;

   // parser state
   hcbd_pkg::phase_type  phase_ff, phase_in;
   logic [SIZE_BITS-1:0] size_accum_ff, size_accum_in;
   logic [SIZE_BITS-1:0] data_left_ff, data_left_in;
   logic                 saw_digit_ff, saw_digit_in;
   logic                 size_bad_ff, size_bad_in;
   logic                 trailer_bad_ff, trailer_bad_in;
   logic                 settled_ff, settled_in;

   logic       rsp_free;
   logic       parse_go;
   logic       req_take;
   logic [4:0] hex;

   // advance the input register into the result register when it has room
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign parse_go = in_valid_ff && rsp_free;
   assign req_chan.ready = !in_valid_ff || rsp_free;
   assign req_take = req_chan.valid && req_chan.ready;

   assign hex = hcbd_pkg::hex_decode(in_byte_ff);

   always_comb begin
      phase_in       = phase_ff;
      size_accum_in  = size_accum_ff;
      data_left_in   = data_left_ff;
      saw_digit_in   = saw_digit_ff;
      size_bad_in    = size_bad_ff;
      trailer_bad_in = trailer_bad_ff;
      settled_in     = settled_ff;
      status_in      = hcbd_pkg::ST_RUN;
      rsp_dv_in      = 1'b0;

      if (!settled_ff) begin
         unique case (phase_ff)
            hcbd_pkg::PH_SIZE_CR, hcbd_pkg::PH_EXT_CR: begin
               if (in_byte_ff == hcbd_pkg::CHAR_LF) begin
                  // line end: judge the size text
                  if (!saw_digit_ff || size_bad_ff) begin
                     settled_in = 1'b1;
                     status_in  = hcbd_pkg::ST_BAD;
                  end else if (size_accum_ff == '0) begin
                     settled_in = 1'b1;
                     status_in  = hcbd_pkg::ST_DONE;
                  end else begin
                     data_left_in = size_accum_ff;
                     phase_in     = hcbd_pkg::PH_DATA;
                  end
               end else if (phase_ff == hcbd_pkg::PH_SIZE_CR) begin
                  // lone CR inside size text taints it
                  size_bad_in = 1'b1;
                  if (in_byte_ff != hcbd_pkg::CHAR_CR) begin
                     phase_in = (in_byte_ff == hcbd_pkg::CHAR_SEMI) ?
                                hcbd_pkg::PH_EXT : hcbd_pkg::PH_SIZE;
                  end
               end else if (in_byte_ff != hcbd_pkg::CHAR_CR) begin
                  phase_in = hcbd_pkg::PH_EXT;
               end
            end
            hcbd_pkg::PH_EXT: begin
               if (in_byte_ff == hcbd_pkg::CHAR_CR) phase_in = hcbd_pkg::PH_EXT_CR;
            end
            hcbd_pkg::PH_DATA: begin
               rsp_dv_in    = 1'b1;
               data_left_in = data_left_ff - SIZE_BITS'(1);
               if (data_left_in == '0) phase_in = hcbd_pkg::PH_TRAIL1;
            end
            hcbd_pkg::PH_TRAIL1: begin
               trailer_bad_in = (in_byte_ff != hcbd_pkg::CHAR_CR);
               phase_in       = hcbd_pkg::PH_TRAIL2;
            end
            hcbd_pkg::PH_TRAIL2: begin
               if (trailer_bad_ff || in_byte_ff != hcbd_pkg::CHAR_LF) begin
                  settled_in = 1'b1;
                  status_in  = hcbd_pkg::ST_BAD;
               end else begin
                  phase_in      = hcbd_pkg::PH_SIZE;
                  size_accum_in = '0;
                  saw_digit_in  = 1'b0;
                  size_bad_in   = 1'b0;
               end
            end
            default: begin
               // size digits
               if (in_byte_ff == hcbd_pkg::CHAR_CR) begin
                  phase_in = hcbd_pkg::PH_SIZE_CR;
               end else if (in_byte_ff == hcbd_pkg::CHAR_SEMI) begin
                  phase_in = hcbd_pkg::PH_EXT;
               end else if (!hex[4]) begin
                  size_bad_in = 1'b1;
               end else begin
                  saw_digit_in = 1'b1;
                  if (!size_bad_ff) begin
                     // overflow if any of the top four bits is already set
                     if (|size_accum_ff[SIZE_BITS-1 -: 4]) begin
                        size_bad_in = 1'b1;
                     end else begin
                        size_accum_in = {size_accum_ff[SIZE_BITS-5:0], hex[3:0]};
                     end
                  end
               end
            end
         endcase
         if (in_last_ff && status_in == hcbd_pkg::ST_RUN) status_in = hcbd_pkg::ST_SHORT;
      end

      // end of buffer: start over for the next message
      if (in_last_ff) begin
         phase_in       = hcbd_pkg::PH_SIZE;
         size_accum_in  = '0;
         data_left_in   = '0;
         saw_digit_in   = 1'b0;
         size_bad_in    = 1'b0;
         trailer_bad_in = 1'b0;
         settled_in     = 1'b0;
      end

      rsp_byte_in = rsp_dv_in ? in_byte_ff : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         phase_ff       <= hcbd_pkg::PH_SIZE;
         size_accum_ff  <= '0;
         data_left_ff   <= '0;
         saw_digit_ff   <= 1'b0;
         size_bad_ff    <= 1'b0;
         trailer_bad_ff <= 1'b0;
         settled_ff     <= 1'b0;
      end else begin
         // hold the request until the parse step takes it
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (parse_go) begin
            in_valid_ff <= 1'b0;
         end

         if (parse_go) begin
            rsp_valid_ff   <= 1'b1;
            phase_ff       <= phase_in;
            size_accum_ff  <= size_accum_in;
            data_left_ff   <= data_left_in;
            saw_digit_ff   <= saw_digit_in;
            size_bad_ff    <= size_bad_in;
            trailer_bad_ff <= trailer_bad_in;
            settled_ff     <= settled_in;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_chan.in_byte;
         in_last_ff <= req_chan.in_last;
      end
      if (parse_go) begin
         rsp_byte_ff   <= rsp_byte_in;
         rsp_dv_ff     <= rsp_dv_in;
         rsp_status_ff <= status_in;
         rsp_eom_ff    <= in_last_ff;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.out_byte       = rsp_byte_ff;
   assign rsp_chan.out_valid      = rsp_dv_ff;
   assign rsp_chan.status         = rsp_status_ff;
   assign rsp_chan.end_of_message = rsp_eom_ff;

   // a payload byte never carries done or invalid
   a_payload_status: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.out_valid |->
         (rsp_chan.status == hcbd_pkg::ST_RUN || rsp_chan.status == hcbd_pkg::ST_SHORT))
      else $error("payload byte with final status");

   // after the last byte of a buffer the parser is back at a fresh size line
   a_last_restart: assert property (@(posedge clock) disable iff (reset)
      parse_go && in_last_ff |=>
         (phase_ff == hcbd_pkg::PH_SIZE && !settled_ff && size_accum_ff == '0))
      else $error("parser not restarted after last byte");

   // a stalled result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |-> !parse_go)
      else $error("result register overwritten while stalled");

   // a data phase always has bytes left to count
   a_data_left: assert property (@(posedge clock) disable iff (reset)
      phase_ff == hcbd_pkg::PH_DATA |-> data_left_ff != '0)
      else $error("data phase with zero count");

endmodule
